@@ sv/chkm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package chkm_pkg;

  localparam int BUCKET_COUNT_DEF = 64;
  localparam int POOL_ENTRIES_DEF = 128;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_FIND   = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;
  localparam logic [1:0] ACT_BLOCK  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISSING = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

@@ sv/chkm_rem.sv @@
`timescale 1ns / 1ps
`default_nettype none

module chkm_rem import chkm_pkg::*; #(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [31:0]   key_i,
  output      logic          done_o,
  output      logic [BW-1:0] bucket_o
);

  localparam bit IsPow2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;

  if (IsPow2) begin : g_mask
    logic          done_q;
    logic [BW-1:0] bucket_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    // a single bucket maps every key to zero
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        bucket_q <= (BUCKET_COUNT == 1) ? '0 : key_i[BW-1:0];
      end
    end

    assign done_o   = done_q;
    assign bucket_o = bucket_q;
  end else begin : g_recip
    // quotient = (key * MAGIC) >> (32 + BW), exact over all 32-bit keys
    localparam logic [32:0] MAGIC =
      33'(((64'd1 << (32 + BW)) / 64'(BUCKET_COUNT)) + 64'd1);

    localparam logic [1:0] P_LO  = 2'd0;
    localparam logic [1:0] P_HI  = 2'd1;
    localparam logic [1:0] P_FIX = 2'd2;

    logic [31:0]   key_q;
    logic [64:0]   acc_q;
    logic [1:0]    phase_q;
    logic          run_q, done_q;
    logic [BW-1:0] rem_q;
    logic [15:0]   mul_a;
    logic [48:0]   prod;
    logic [BW-1:0] qb;

    // one 16 x 33 multiplier, used on the low then the high key half
    always_comb begin
      mul_a = (phase_q == P_LO) ? key_q[15:0] : key_q[31:16];
      prod  = 49'(mul_a) * 49'(MAGIC);
      // only the low bits of quotient times bucket count reach the remainder
      qb    = BW'(acc_q[32+BW +: BW] * BW'(BUCKET_COUNT));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        run_q   <= 1'b0;
        done_q  <= 1'b0;
        phase_q <= P_LO;
      end else begin
        done_q <= 1'b0;
        if (start_i) begin
          run_q   <= 1'b1;
          phase_q <= P_LO;
        end else if (run_q) begin
          phase_q <= phase_q + 2'd1;
          if (phase_q == P_FIX) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end else if (run_q) begin
        case (phase_q)
          P_LO:    acc_q <= 65'(prod);
          P_HI:    acc_q <= acc_q + {prod, 16'd0};
          default: rem_q <= key_q[BW-1:0] - qb;
        endcase
      end
    end

    assign done_o   = done_q;
    assign bucket_o = rem_q;
  end

endmodule

`default_nettype wire

@@ sv/chkm_cmp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module chkm_cmp import chkm_pkg::*; (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output      cmp_res_t    res_o
);

  assign res_o.eq = (a_i == b_i);
  assign res_o.gt = (a_i > b_i);

endmodule

`default_nettype wire

@@ sv/chained_hash_key_map.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Key-to-value map with separately chained buckets over a fixed entry pool.
// Command channel: an item (action_i, key_i, entry_value_i, num_keys_i) is
// taken at a rising edge with start_i high and busy_o low. busy_o stays high
// from the next cycle until the result is out. Each item gives one result
// (status_o, found_value_o, block_start_o), shown for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must take it then.
// Sequence after the accepting edge: a free-key-block request passes
// through S_BLOCK only. Insert, find and remove hash the key (a registered
// mask when BUCKET_COUNT is a power of two, the P_LO, P_HI and P_FIX phases
// of the shared reciprocal multiplier otherwise), read the bucket head, then
// compare one chain entry per cycle on the single entry memory port. A hit on
// the k-th entry ends after k compares; remove then passes through S_FREE to
// push the entry on the free list. A miss passes through S_MISS and an insert
// miss with a free entry then through S_ALLOC to pop the free list. The next
// item may be taken in the cycle that done_o is high.
// Reset: busy_o stays high after reset while the bucket head memory is
// cleared to empty chains; the free list needs no pass.
module chained_hash_key_map import chkm_pkg::*; #(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] entry_value_i,
  input  wire logic [30:0] num_keys_i,
  output      logic        done_o,
  output      logic [1:0]  status_o,
  output      logic [31:0] found_value_o,
  output      logic [31:0] block_start_o
);

  localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
  localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NIL = LW'(POOL_ENTRIES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_HASH  = 4'd2;
  localparam logic [3:0] S_HEAD  = 4'd3;
  localparam logic [3:0] S_CMP   = 4'd4;
  localparam logic [3:0] S_FREE  = 4'd5;
  localparam logic [3:0] S_MISS  = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_BLOCK = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [BW-1:0] clr_q;
  logic [1:0]    act_q;
  logic [31:0]   key_q, val_q;
  logic [30:0]   nkeys_q;
  logic [31:0]   largest_q;
  logic [LW-1:0] free_q, fresh_q;
  logic [BW-1:0] bucket_q;
  logic [LW-1:0] head_q, cur_q, prev_q;
  logic          gt_q;
  logic          done_q;
  logic [1:0]    status_q;
  logic [31:0]   found_q, block_q;

  // memories
  logic [LW-1:0] bucket_mem [BUCKET_COUNT];
  logic [31:0]   key_mem    [POOL_ENTRIES];
  logic [31:0]   val_mem    [POOL_ENTRIES];
  logic [LW-1:0] link_mem   [POOL_ENTRIES];

  logic [LW-1:0] head_rd, link_rd;
  logic [31:0]   key_rd, val_rd;
  logic [IW-1:0] ent_ra, rd_idx_q;
  logic [LW-1:0] link_eff;

  logic          bk_we;
  logic [BW-1:0] bk_wa;
  logic [LW-1:0] bk_wd;
  logic          lk_we;
  logic [IW-1:0] lk_wa;
  logic [LW-1:0] lk_wd;
  logic          vl_we;
  logic [IW-1:0] vl_wa;
  logic          ky_we;

  logic          rem_start, rem_done;
  logic [BW-1:0] rem_bucket;
  logic [31:0]   cmp_a, cmp_b;
  cmp_res_t      cmp_res;

  logic          accept;
  logic          fin;
  logic [1:0]    fin_status;
  logic [31:0]   fin_found, fin_block;
  logic          grow;

  assign accept    = (state_q == S_IDLE) && start_i;
  assign rem_start = accept && (action_i != ACT_BLOCK);

  chkm_rem #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .key_i   (key_i),
    .done_o  (rem_done),
    .bucket_o(rem_bucket)
  );

  chkm_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .res_o(cmp_res)
  );

  // one comparator serves the largest-key checks and the chain key match
  always_comb begin
    case (state_q)
      S_BLOCK: begin
        cmp_a = ALL_ONES - {1'b0, nkeys_q};
        cmp_b = largest_q;
      end
      S_CMP: begin
        cmp_a = key_rd;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = largest_q;
      end
    endcase
  end

  // entries at or above the fill mark were never used and still link onward
  assign link_eff = ({1'b0, rd_idx_q} >= (IW+1)'(fresh_q)) ?
                    LW'({1'b0, rd_idx_q} + (IW+1)'(1)) : link_rd;

  always_comb begin
    case (state_q)
      S_HEAD:  ent_ra = head_rd[IW-1:0];
      S_CMP:   ent_ra = link_eff[IW-1:0];
      default: ent_ra = free_q[IW-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    head_rd  <= bucket_mem[rem_bucket];
    key_rd   <= key_mem[ent_ra];
    val_rd   <= val_mem[ent_ra];
    link_rd  <= link_mem[ent_ra];
    rd_idx_q <= ent_ra;
    if (bk_we) begin
      bucket_mem[bk_wa] <= bk_wd;
    end
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    if (vl_we) begin
      val_mem[vl_wa] <= val_q;
    end
    if (ky_we) begin
      key_mem[free_q[IW-1:0]] <= key_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    bk_we      = 1'b0;
    bk_wa      = bucket_q;
    bk_wd      = NIL;
    lk_we      = 1'b0;
    lk_wa      = cur_q[IW-1:0];
    lk_wd      = free_q;
    vl_we      = 1'b0;
    vl_wa      = cur_q[IW-1:0];
    ky_we      = 1'b0;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_found  = '0;
    fin_block  = '0;
    grow       = 1'b0;
    case (state_q)
      S_CLEAR: begin
        bk_we = 1'b1;
        bk_wa = clr_q;
        if (clr_q == BW'(BUCKET_COUNT - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          state_d = (action_i == ACT_BLOCK) ? S_BLOCK : S_HASH;
        end
      end
      S_HASH: begin
        if (rem_done) begin
          state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        if ((act_q == ACT_FIND && gt_q) || head_rd >= NIL) begin
          state_d = S_MISS;
        end else begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (cmp_res.eq) begin
          case (act_q)
            ACT_INSERT: begin
              vl_we   = 1'b1;
              grow    = gt_q;
              fin     = 1'b1;
              state_d = S_IDLE;
            end
            ACT_FIND: begin
              fin_found = val_rd;
              fin       = 1'b1;
              state_d   = S_IDLE;
            end
            default: begin
              // unlink from the predecessor or the bucket head
              if (prev_q >= NIL) begin
                bk_we = 1'b1;
                bk_wd = link_eff;
              end else begin
                lk_we = 1'b1;
                lk_wa = prev_q[IW-1:0];
                lk_wd = link_eff;
              end
              state_d = S_FREE;
            end
          endcase
        end else if (link_eff >= NIL) begin
          state_d = S_MISS;
        end
      end
      S_FREE: begin
        lk_we   = 1'b1;
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_MISS: begin
        if (act_q == ACT_INSERT && free_q < NIL) begin
          state_d = S_ALLOC;
        end else begin
          fin        = 1'b1;
          fin_status = (act_q == ACT_INSERT) ? ST_FULL : ST_MISSING;
          state_d    = S_IDLE;
        end
      end
      S_ALLOC: begin
        // push the free-list head onto the front of the chain
        ky_we   = 1'b1;
        vl_we   = 1'b1;
        vl_wa   = free_q[IW-1:0];
        lk_we   = 1'b1;
        lk_wa   = free_q[IW-1:0];
        lk_wd   = head_q;
        bk_we   = 1'b1;
        bk_wd   = free_q;
        grow    = gt_q;
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      S_BLOCK: begin
        if (cmp_res.gt) begin
          fin_block = largest_q + 32'd1;
        end
        fin     = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      largest_q <= '0;
      free_q    <= '0;
      fresh_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= fin;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + BW'(1);
      end
      if (grow) begin
        largest_q <= key_q;
      end
      if (state_q == S_FREE) begin
        free_q <= cur_q;
      end else if (state_q == S_ALLOC) begin
        free_q <= link_eff;
        if (free_q == fresh_q) begin
          fresh_q <= fresh_q + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_i;
      key_q   <= key_i;
      val_q   <= entry_value_i;
      nkeys_q <= num_keys_i;
    end
    if (state_q == S_HASH) begin
      gt_q     <= cmp_res.gt;
      bucket_q <= rem_bucket;
    end
    if (state_q == S_HEAD) begin
      head_q <= head_rd;
      cur_q  <= head_rd;
      prev_q <= NIL;
    end
    if (state_q == S_CMP && !cmp_res.eq) begin
      prev_q <= cur_q;
      cur_q  <= link_eff;
    end
    if (fin) begin
      status_q <= fin_status;
      found_q  <= fin_found;
      block_q  <= fin_block;
    end
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_value_o = found_q;
  assign block_start_o = block_q;

endmodule

`default_nettype wire
